>>> rtl/cpu_state_share_per_mille_core_defines.svh
// ----------------------------------------------------------------------------
// CPU state share core - assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef CPU_STATE_SHARE_PER_MILLE_CORE_DEFINES_SVH
`define CPU_STATE_SHARE_PER_MILLE_CORE_DEFINES_SVH

// Normal check, off while reset is high.
`define CSSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that must also hold across reset.
`define CSSP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> rtl/cssp_pkg.sv
// ----------------------------------------------------------------------------
// CPU state share package
// Fixed field widths, packing offsets and the sequencer state type.
// ----------------------------------------------------------------------------
package cssp_pkg;

   // transaction fields
   localparam int CHAN_W        = 4;
   localparam int COUNT_W       = 32;
   localparam int FIELD_STATES  = 6;
   localparam int SHARE_W       = 10;
   localparam int TOTAL_W       = 35;
   localparam int REQ_COUNT_LSB = CHAN_W;
   localparam int REQ_TDATA_W   = 200;
   localparam int RSP_TDATA_W   = 96;

   // arithmetic
   localparam int PER_MILLE = 1000;
   localparam int QUO_W     = 10;   // quotient never exceeds 1000
   localparam int STEP_W    = 4;    // counts QUO_W divider steps
   localparam int CARRY_W   = 3;    // serial sum carry of up to six bits
   localparam int SUM_W     = 4;
   localparam int ST_W      = 3;    // indexes up to six states

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_LOAD      = 7'b0000010,
      S_DIFF      = 7'b0000100,
      S_TOTAL     = 7'b0001000,
      S_DIV_START = 7'b0010000,
      S_DIV_WAIT  = 7'b0100000,
      S_EMIT      = 7'b1000000
   } cssp_state_type;

endpackage

>>> rtl/cssp_div.sv
// ----------------------------------------------------------------------------
// CPU state share divider
// Restoring divider, one quotient bit per cycle, QUO_W bit quotient.
// ----------------------------------------------------------------------------
module cssp_div
   import cssp_pkg::*;
#(
   parameter int COUNTER_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNTER_BITS+QUO_W-1:0]     dividend,
   input  logic [COUNTER_BITS+CARRY_W-1:0]   divisor,
   output logic                              done,
   output logic [QUO_W-1:0]                  quotient
);

   localparam int NUM_W = COUNTER_BITS + QUO_W;
   localparam int DEN_W = COUNTER_BITS + CARRY_W;
   localparam int DSH_W = DEN_W + QUO_W - 1;

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // divisor is pre-shifted by QUO_W-1, so dividend < divisor * 2^QUO_W
   assign fits = DSH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {divisor, {(QUO_W-1){1'b0}}};
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/cpu_state_share_per_mille_core.sv
// ----------------------------------------------------------------------------
// CPU state share core
// Per-mille share of elapsed ticks per CPU state, per channel of counters.
// ----------------------------------------------------------------------------
// One req transaction carries a channel and six free-running tick counters.
// The core subtracts that channel's stored sample (modulo 2^COUNTER_BITS,
// so counter wrap is harmless), sums the deltas into a total (zero becomes
// one), and returns one rsp transaction holding each state's share as
// round(delta*1000/total) plus the total itself. The new sample replaces the
// stored one; after reset every channel reads as zero, so a channel's first
// sample is measured from zero. Channel codes of CHANNELS or more wrap modulo
// CHANNELS. One transaction is in flight at a time: req_tready stays low from an
// accept until the result is emitted, and emitting waits for the rsp register
// to be free. The work runs in order: a load step, the bit-serial subtract/sum
// pass (one counter bit per cycle for all states), a fix-up of the total, the
// single shared restoring divider (QUO_W steps plus start and hand-off per
// state) and the emit step. The result
// sits in an output register, so a new transaction is taken while rsp waits.
// ----------------------------------------------------------------------------
module cpu_state_share_per_mille_core
   import cssp_pkg::*;
#(
   parameter int STATE_COUNT  = 6,
   parameter int COUNTER_BITS = 32,
   parameter int CHANNELS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: channel[3:0], count_0 .. count_5 (32 bits each), zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: share_0 .. share_5 (10 bits each), tick_total[94:60], pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W = STATE_COUNT * COUNTER_BITS;
   localparam int TOT_W = COUNTER_BITS + CARRY_W;
   localparam int NUM_W = COUNTER_BITS + QUO_W;
   localparam int BIT_W = $clog2(COUNTER_BITS);
   localparam int CODES = 2 ** CHAN_W;

   cssp_state_type state_ff, state_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [CH_W-1:0]         chan_map [CODES];
   logic [CH_W-1:0]         req_idx;
   logic [ROW_W-1:0]        req_row;

   // previous samples, one row per channel; valid bit marks a written row
   logic [ROW_W-1:0]        prev_mem [CHANNELS];
   logic [ROW_W-1:0]        rd_ff;
   logic                    rd_vld_ff;
   logic [CHANNELS-1:0]     vld_ff, vld_in;

   // serial datapath: now_ff shifts out the sample and shifts in the delta
   logic [COUNTER_BITS-1:0] now_ff  [STATE_COUNT];
   logic [COUNTER_BITS-1:0] now_in  [STATE_COUNT];
   logic [COUNTER_BITS-1:0] prev_ff [STATE_COUNT];
   logic [COUNTER_BITS-1:0] prev_in [STATE_COUNT];
   logic [STATE_COUNT-1:0]  borrow_ff, borrow_in;
   logic [STATE_COUNT-1:0]  dbit;
   logic [COUNTER_BITS-1:0] tot_lo_ff, tot_lo_in;
   logic [CARRY_W-1:0]      carry_ff, carry_in;
   logic [SUM_W-1:0]        bit_sum;
   logic [TOT_W-1:0]        total_raw;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [BIT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [ST_W-1:0]         st_cnt_ff, st_cnt_in;
   logic [SHARE_W-1:0]      share_ff [STATE_COUNT];
   logic [SHARE_W-1:0]      share_in [STATE_COUNT];

   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        div_num;
   logic [QUO_W-1:0]        div_quo;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_TDATA_W-1:0]  rsp_pack;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;

   // channel code to memory row, modulo CHANNELS
   for (genvar g = 0; g < CODES; g++) begin : g_chan
      assign chan_map[g] = CH_W'(g % CHANNELS);
   end
   assign req_idx = chan_map[req_tdata[CHAN_W-1:0]];

   for (genvar s = 0; s < STATE_COUNT; s++) begin : g_row
      assign req_row[s*COUNTER_BITS +: COUNTER_BITS] =
         req_tdata[REQ_COUNT_LSB + s*COUNT_W +: COUNTER_BITS];
      assign dbit[s] = now_ff[s][0] ^ prev_ff[s][0] ^ borrow_ff[s];
   end

   // read-before-write: the row read at accept is the old sample
   always_ff @(posedge clock) begin
      if (req_fire) begin
         prev_mem[req_idx] <= req_row;
         rd_ff             <= prev_mem[req_idx];
         rd_vld_ff         <= vld_ff[req_idx];
      end
   end

   always_comb begin
      bit_sum = SUM_W'(carry_ff);
      for (int s = 0; s < STATE_COUNT; s++) begin
         bit_sum = bit_sum + SUM_W'(dbit[s]);
      end
   end

   assign total_raw = {carry_ff, tot_lo_ff};
   assign div_num   = NUM_W'(now_ff[0]) * NUM_W'(PER_MILLE) + NUM_W'(total_ff >> 1);

   always_comb begin
      rsp_pack = '0;
      for (int s = 0; s < STATE_COUNT; s++) begin
         rsp_pack[s*SHARE_W +: SHARE_W] = share_ff[s];
      end
      rsp_pack[FIELD_STATES*SHARE_W +: TOTAL_W] = TOTAL_W'(total_ff);
   end

   always_comb begin
      state_in     = state_ff;
      vld_in       = vld_ff;
      now_in       = now_ff;
      prev_in      = prev_ff;
      borrow_in    = borrow_ff;
      tot_lo_in    = tot_lo_ff;
      carry_in     = carry_ff;
      total_in     = total_ff;
      bit_cnt_in   = bit_cnt_ff;
      st_cnt_in    = st_cnt_ff;
      share_in     = share_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               for (int s = 0; s < STATE_COUNT; s++) begin
                  now_in[s] = req_row[s*COUNTER_BITS +: COUNTER_BITS];
               end
               vld_in[req_idx] = 1'b1;
               state_in        = S_LOAD;
            end
         end
         S_LOAD: begin
            for (int s = 0; s < STATE_COUNT; s++) begin
               prev_in[s] = rd_vld_ff ? rd_ff[s*COUNTER_BITS +: COUNTER_BITS] : '0;
            end
            borrow_in  = '0;
            carry_in   = '0;
            bit_cnt_in = '0;
            state_in   = S_DIFF;
         end
         S_DIFF: begin
            // LSB first: serial subtract per state, serial sum across states
            for (int s = 0; s < STATE_COUNT; s++) begin
               now_in[s]    = {dbit[s], now_ff[s][COUNTER_BITS-1:1]};
               prev_in[s]   = prev_ff[s] >> 1;
               borrow_in[s] = (~now_ff[s][0] & prev_ff[s][0]) |
                              (~(now_ff[s][0] ^ prev_ff[s][0]) & borrow_ff[s]);
            end
            tot_lo_in  = {bit_sum[0], tot_lo_ff[COUNTER_BITS-1:1]};
            carry_in   = bit_sum[SUM_W-1:1];
            bit_cnt_in = bit_cnt_ff + BIT_W'(1);
            if (bit_cnt_ff == BIT_W'(COUNTER_BITS-1)) begin
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            // no elapsed time: divide by one so every share is zero
            total_in  = (total_raw == '0) ? TOT_W'(1) : total_raw;
            st_cnt_in = '0;
            state_in  = S_DIV_START;
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               // rotate deltas down and quotients in from the top
               for (int s = 0; s < STATE_COUNT - 1; s++) begin
                  now_in[s]   = now_ff[s+1];
                  share_in[s] = share_ff[s+1];
               end
               share_in[STATE_COUNT-1] = SHARE_W'(div_quo);
               st_cnt_in = st_cnt_ff + ST_W'(1);
               if (st_cnt_ff == ST_W'(STATE_COUNT-1)) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DIV_START;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_pack;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      prev_ff     <= prev_in;
      borrow_ff   <= borrow_in;
      tot_lo_ff   <= tot_lo_in;
      carry_ff    <= carry_in;
      total_ff    <= total_in;
      bit_cnt_ff  <= bit_cnt_in;
      st_cnt_ff   <= st_cnt_in;
      share_ff    <= share_in;
      rsp_data_ff <= rsp_data_in;
   end

   cssp_div #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/cssp_checker.sv
// ----------------------------------------------------------------------------
// CPU state share checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "cpu_state_share_per_mille_core_defines.svh"

module cssp_checker
   import cssp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic share_ok;

   // every share field stays within 0..1000
   always_comb begin
      share_ok = 1'b1;
      for (int s = 0; s < FIELD_STATES; s++) begin
         if (rsp_tdata[s*SHARE_W +: SHARE_W] > SHARE_W'(PER_MILLE)) begin
            share_ok = 1'b0;
         end
      end
   end

   `CSSP_ASSERT_RST(a_rst_no_rsp, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   // one transaction at a time: ready must drop right after an accept
   `CSSP_ASSERT(a_busy_after_req, req_tvalid && req_tready |=> !req_tready, "ready after accept")

   `CSSP_ASSERT(a_total_nonzero, rsp_tvalid |-> rsp_tdata[94:60] != 35'd0, "zero tick_total")

   `CSSP_ASSERT(a_share_range, rsp_tvalid |-> share_ok, "share above 1000")

   `CSSP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp moved")

endmodule

bind cpu_state_share_per_mille_core cssp_checker u_cssp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
